### rtl/core/doe_mbx_pkg.sv
// Package for the mailbox register block: request and result payload types,
// command codes and register indexes. No dependencies.
package doe_mbx_pkg;

	typedef enum logic [1:0] {
		CMD_HOST_RD = 2'd0,
		CMD_HOST_WR = 2'd1,
		CMD_SYS_RD  = 2'd2,
		CMD_SYS_WR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MOP_NONE  = 2'd0,
		MOP_READ  = 2'd1,
		MOP_WRITE = 2'd2
	} mop_t;

	// Host port register indexes.
	localparam logic [4:0] H_INTR_STATE  = 5'd0;
	localparam logic [4:0] H_INTR_ENABLE = 5'd1;
	localparam logic [4:0] H_INTR_TEST   = 5'd2;
	localparam logic [4:0] H_ALERT_TEST  = 5'd3;
	localparam logic [4:0] H_CONTROL     = 5'd4;
	localparam logic [4:0] H_STATUS      = 5'd5;
	localparam logic [4:0] H_RANGE_REGWEN = 5'd6;
	localparam logic [4:0] H_RANGE_VALID = 5'd7;
	localparam logic [4:0] H_IN_BASE     = 5'd8;
	localparam logic [4:0] H_IN_LIMIT    = 5'd9;
	localparam logic [4:0] H_IN_WPTR     = 5'd10;
	localparam logic [4:0] H_OUT_BASE    = 5'd11;
	localparam logic [4:0] H_OUT_LIMIT   = 5'd12;
	localparam logic [4:0] H_OUT_RPTR    = 5'd13;
	localparam logic [4:0] H_OUT_SIZE    = 5'd14;
	localparam logic [4:0] H_MSG_ADDR    = 5'd15;
	localparam logic [4:0] H_MSG_DATA    = 5'd16;

	// System port register indexes.
	localparam logic [4:0] S_MSG_ADDR   = 5'd0;
	localparam logic [4:0] S_MSG_DATA   = 5'd1;
	localparam logic [4:0] S_CONTROL    = 5'd2;
	localparam logic [4:0] S_STATUS     = 5'd3;
	localparam logic [4:0] S_WRITE_DATA = 5'd4;
	localparam logic [4:0] S_READ_DATA  = 5'd5;

	localparam logic [3:0] MUBI4_TRUE = 4'h6;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [4:0]  reg_index;
		logic [31:0] wdata;
		logic [31:0] mem_rdata;
		logic        mem_fault;
	} req_t;

	typedef struct packed {
		logic [31:0] rdata;
		logic [1:0]  mem_op;
		logic [31:0] mem_addr;
		logic [31:0] mem_wdata;
		logic        irq_ready;
		logic        irq_abort;
		logic        irq_error;
		logic        alert_recov;
		logic        alert_crit;
	} rsp_t;

endpackage

### rtl/core/doe_mbx_core.sv
// Register state and single-pass access logic of the mailbox.
// Depends on doe_mbx_pkg.
module doe_mbx_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  doe_mbx_pkg::req_t  req,
	output doe_mbx_pkg::rsp_t  rsp
);
	import doe_mbx_pkg::*;

	logic [2:0]  intr_pending_q, intr_enabled_q;
	logic        abort_q, error_q, busy_q, sys_irq_pend_q, sys_irq_en_q;
	logic [3:0]  range_lock_q;
	logic        range_valid_q;
	logic [31:0] bounds_q [4];
	logic [31:0] in_ptr_q, out_ptr_q;
	logic [9:0]  obj_words_q;
	logic [31:0] msg_q [2];
	logic [1:0]  alert_q;

	logic [2:0]  intr_pending_d, intr_enabled_d;
	logic        abort_d, error_d, busy_d, sys_irq_pend_d, sys_irq_en_d;
	logic [3:0]  range_lock_d;
	logic        range_valid_d;
	logic [31:0] bounds_d [4];
	logic [31:0] in_ptr_d, out_ptr_d;
	logic [9:0]  obj_words_d;
	logic [31:0] msg_d [2];
	logic [1:0]  alert_d;
	logic [31:0] rdata;
	logic [1:0]  mop;
	logic [31:0] maddr, mwd;
	logic [9:0]  ow_tmp;
	logic [2:0]  lv;

	// Next-state logic for one access.
	always_comb begin
		intr_pending_d = intr_pending_q;
		intr_enabled_d = intr_enabled_q;
		abort_d = abort_q;
		error_d = error_q;
		busy_d = busy_q;
		sys_irq_pend_d = sys_irq_pend_q;
		sys_irq_en_d = sys_irq_en_q;
		range_lock_d = range_lock_q;
		range_valid_d = range_valid_q;
		bounds_d = bounds_q;
		in_ptr_d = in_ptr_q;
		out_ptr_d = out_ptr_q;
		obj_words_d = obj_words_q;
		msg_d = msg_q;
		alert_d = alert_q;
		rdata = '0;
		mop = MOP_NONE;
		maddr = '0;
		mwd = '0;
		ow_tmp = obj_words_q;
		unique case (cmd_t'(req.cmd))
			CMD_HOST_RD: begin
				unique case (req.reg_index)
					H_INTR_STATE:   rdata = {29'd0, intr_pending_q};
					H_INTR_ENABLE:  rdata = {29'd0, intr_enabled_q};
					H_CONTROL:      rdata = {30'd0, error_q, abort_q};
					H_STATUS:       rdata = {29'd0, sys_irq_en_q, sys_irq_pend_q, busy_q};
					H_RANGE_REGWEN: rdata = {28'd0, range_lock_q};
					H_RANGE_VALID:  rdata = {31'd0, range_valid_q};
					H_IN_BASE:      rdata = bounds_q[0];
					H_IN_LIMIT:     rdata = bounds_q[1];
					H_IN_WPTR:      rdata = in_ptr_q;
					H_OUT_BASE:     rdata = bounds_q[2];
					H_OUT_LIMIT:    rdata = bounds_q[3];
					H_OUT_RPTR:     rdata = out_ptr_q;
					H_OUT_SIZE:     rdata = {22'd0, obj_words_q};
					H_MSG_ADDR:     rdata = msg_q[0];
					H_MSG_DATA:     rdata = msg_q[1];
					default:        rdata = '0;
				endcase
			end
			CMD_HOST_WR: begin
				unique case (req.reg_index)
					H_INTR_STATE:  intr_pending_d = intr_pending_q & ~req.wdata[2:0];
					H_INTR_ENABLE: intr_enabled_d = req.wdata[2:0];
					H_INTR_TEST:   intr_pending_d = intr_pending_q | req.wdata[2:0];
					H_ALERT_TEST: begin
						if (req.wdata[1:0] != 2'b00) begin
							alert_d = {req.wdata[0], req.wdata[1]};
						end
					end
					H_CONTROL: begin
						if (req.wdata[0]) begin
							busy_d = 1'b0;
							in_ptr_d = bounds_q[0];
							out_ptr_d = bounds_q[2];
							abort_d = 1'b0;
						end
						if (req.wdata[1]) begin
							error_d = 1'b1;
							if (sys_irq_en_q) sys_irq_pend_d = 1'b1;
							intr_pending_d[2] = 1'b1;
						end
					end
					H_RANGE_REGWEN: range_lock_d = range_lock_q & req.wdata[3:0];
					H_RANGE_VALID: begin
						range_valid_d = req.wdata[0];
						if (!range_valid_q && req.wdata[0]) begin
							busy_d = 1'b0;
							in_ptr_d = bounds_q[0];
							out_ptr_d = bounds_q[2];
						end else begin
							busy_d = 1'b1;
						end
					end
					H_IN_BASE:   if (range_lock_q == MUBI4_TRUE) bounds_d[0] = {req.wdata[31:2], 2'b00};
					H_IN_LIMIT:  if (range_lock_q == MUBI4_TRUE) bounds_d[1] = {req.wdata[31:2], 2'b00};
					H_OUT_BASE:  if (range_lock_q == MUBI4_TRUE) bounds_d[2] = {req.wdata[31:2], 2'b00};
					H_OUT_LIMIT: if (range_lock_q == MUBI4_TRUE) bounds_d[3] = {req.wdata[31:2], 2'b00};
					H_OUT_SIZE: begin
						if (!error_q && !abort_q) begin
							obj_words_d = req.wdata[9:0];
							if (req.wdata[9:0] != 10'd0) begin
								out_ptr_d = bounds_q[2];
								if (sys_irq_en_q) sys_irq_pend_d = 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
			CMD_SYS_RD: begin
				unique case (req.reg_index)
					S_MSG_ADDR: rdata = msg_q[0];
					S_MSG_DATA: rdata = msg_q[1];
					S_CONTROL:  rdata = {30'd0, sys_irq_en_q, 1'b0};
					S_STATUS:   rdata = {(obj_words_q != 10'd0), 28'd0, error_q,
						sys_irq_pend_q, busy_q};
					S_READ_DATA: begin
						if (range_valid_q && !error_q && obj_words_q != 10'd0) begin
							mop = MOP_READ;
							maddr = {out_ptr_q[31:2], 2'b00};
							if (req.mem_fault) alert_d[0] = 1'b1;
							else rdata = req.mem_rdata;
						end
					end
					default: ;
				endcase
			end
			CMD_SYS_WR: begin
				unique case (req.reg_index)
					S_MSG_ADDR: msg_d[0] = req.wdata;
					S_MSG_DATA: msg_d[1] = req.wdata;
					S_CONTROL: begin
						if (range_valid_q) begin
							if (req.wdata[0]) begin
								abort_d = 1'b1;
								obj_words_d = '0;
								busy_d = 1'b1;
								error_d = 1'b0;
								intr_pending_d[1] = 1'b1;
							end else if (req.wdata[31] && !abort_q) begin
								busy_d = 1'b1;
								intr_pending_d[0] = 1'b1;
							end
							sys_irq_en_d = req.wdata[1];
						end
					end
					S_STATUS: if (req.wdata[1]) sys_irq_pend_d = 1'b0;
					S_WRITE_DATA: begin
						if (range_valid_q && !error_q && !busy_q) begin
							if (in_ptr_q >= bounds_q[1]) begin
								error_d = 1'b1;
								if (sys_irq_en_q) sys_irq_pend_d = 1'b1;
								intr_pending_d[2] = 1'b1;
							end else begin
								mop = MOP_WRITE;
								maddr = {in_ptr_q[31:2], 2'b00};
								mwd = req.wdata;
								if (req.mem_fault) begin
									error_d = 1'b1;
									if (sys_irq_en_q) sys_irq_pend_d = 1'b1;
									intr_pending_d[2] = 1'b1;
									alert_d[0] = 1'b1;
								end else begin
									in_ptr_d = in_ptr_q + 32'd4;
								end
							end
						end
					end
					S_READ_DATA: begin
						if (range_valid_q && !error_q) begin
							if (obj_words_q != 10'd0) begin
								out_ptr_d = out_ptr_q + 32'd4;
								ow_tmp = obj_words_q - 10'd1;
							end
							obj_words_d = ow_tmp;
							if (ow_tmp == 10'd0) begin
								busy_d = 1'b0;
								in_ptr_d = bounds_q[0];
								out_ptr_d = bounds_q[2];
							end
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// State registers, updated once per accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intr_pending_q <= '0;
			intr_enabled_q <= '0;
			abort_q <= 1'b0;
			error_q <= 1'b0;
			busy_q <= 1'b1;
			sys_irq_pend_q <= 1'b0;
			sys_irq_en_q <= 1'b0;
			range_lock_q <= MUBI4_TRUE;
			range_valid_q <= 1'b0;
			bounds_q <= '{default: '0};
			in_ptr_q <= '0;
			out_ptr_q <= '0;
			obj_words_q <= '0;
			msg_q <= '{default: '0};
			alert_q <= '0;
		end else if (en) begin
			intr_pending_q <= intr_pending_d;
			intr_enabled_q <= intr_enabled_d;
			abort_q <= abort_d;
			error_q <= error_d;
			busy_q <= busy_d;
			sys_irq_pend_q <= sys_irq_pend_d;
			sys_irq_en_q <= sys_irq_en_d;
			range_lock_q <= range_lock_d;
			range_valid_q <= range_valid_d;
			bounds_q <= bounds_d;
			in_ptr_q <= in_ptr_d;
			out_ptr_q <= out_ptr_d;
			obj_words_q <= obj_words_d;
			msg_q <= msg_d;
			alert_q <= alert_d;
		end
	end

	// Result of this access; the interrupt and alert outputs use the updated state.
	assign lv = intr_pending_d & intr_enabled_d;
	assign rsp = '{rdata: rdata, mem_op: mop, mem_addr: maddr, mem_wdata: mwd,
		irq_ready: lv[0], irq_abort: lv[1], irq_error: lv[2],
		alert_recov: alert_d[0], alert_crit: alert_d[1]};

	// The inbound pointer only moves by one word or reloads from its base.
	a_in_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		$past(en) && (in_ptr_q != $past(in_ptr_q)) |->
		(in_ptr_q == $past(in_ptr_q) + 32'd4) || (in_ptr_q == $past(bounds_q[0])))
		else $error("inbound pointer jumped");
	// A memory write never happens at or past the inbound limit.
	a_wr_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(mop == MOP_WRITE) |-> (in_ptr_q < bounds_q[1]))
		else $error("memory write past limit");
	// A memory read requires a pending object.
	a_rd_obj: assert property (@(posedge clk) disable iff (!arst_n)
		(mop == MOP_READ) |-> (obj_words_q != 10'd0))
		else $error("memory read with empty object");
endmodule

### rtl/core/doe_mailbox_registers.sv
// Top level of the mailbox register block: input register, core logic and
// output register with stall handling. Depends on doe_mbx_pkg, doe_mbx_core.
// A result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle; the output register stalls the input.
// Reset: asynchronous, active low; busy set, range lock at multibit true.
module doe_mailbox_registers (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  doe_mbx_pkg::req_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output doe_mbx_pkg::rsp_t  out_data
);
	import doe_mbx_pkg::*;

	logic accept;
	rsp_t rsp;

	// A request enters when the output slot is empty or draining.
	assign in_stall = out_valid && out_stall;
	assign accept = in_valid && !in_stall;

	doe_mbx_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (accept),
		.req    (in_data),
		.rsp    (rsp)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!in_stall) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data <= rsp;
		end
	end
endmodule
